// File: src/iac_pkg.sv
// Package for the intruder alarm controller: modes, config layout, reset values.
package iac_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam logic [15:0] SETTLE_RESET = 16'd1000;
    localparam logic [15:0] BLINK_HALF_RESET = 16'd500;
    localparam logic [3:0]  BLINK_COUNT_RESET = 4'd3;
    localparam logic [15:0] ENTRY_DELAY_RESET = 16'd10000;
    localparam logic [15:0] ALARM_HOLD_RESET = 16'd2000;

    localparam int CFG_ADDR_BITS = 5;

    typedef enum logic [2:0] {
        REG_SETTLE      = 3'd0,
        REG_BLINK_HALF  = 3'd1,
        REG_BLINK_COUNT = 3'd2,
        REG_ENTRY_DELAY = 3'd3,
        REG_ALARM_HOLD  = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_SETTLING = 3'd0,
        MODE_DISARMED = 3'd1,
        MODE_ARMING   = 3'd2,
        MODE_ARMED    = 3'd3,
        MODE_ENTRY    = 3'd4,
        MODE_SOUNDING = 3'd5,
        MODE_LATCHED  = 3'd6
    } mode_t;

    typedef struct packed {
        logic [15:0] settle_ticks;
        logic [15:0] blink_half_ticks;
        logic [3:0]  blink_count;
        logic [15:0] entry_delay_ticks;
        logic [15:0] alarm_hold_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [3:0] blinks_done;
        logic       blink_lit;
    } ctl_t;

    typedef struct packed {
        logic       status_lamp;
        logic       armed_lamp;
        logic       siren_lamp;
        logic       notify_pulse;
        logic [2:0] mode_code;
    } res_t;

endpackage

// File: src/iac_cfg_regs.sv
// APB configuration registers of the intruder alarm controller.
module iac_cfg_regs
    import iac_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output cfg_t                     cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks      <= SETTLE_RESET;
            cfg_reg.blink_half_ticks  <= BLINK_HALF_RESET;
            cfg_reg.blink_count       <= BLINK_COUNT_RESET;
            cfg_reg.entry_delay_ticks <= ENTRY_DELAY_RESET;
            cfg_reg.alarm_hold_ticks  <= ALARM_HOLD_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SETTLE:      cfg_reg.settle_ticks      <= pwdata[15:0];
                REG_BLINK_HALF:  cfg_reg.blink_half_ticks  <= pwdata[15:0];
                REG_BLINK_COUNT: cfg_reg.blink_count       <= pwdata[3:0];
                REG_ENTRY_DELAY: cfg_reg.entry_delay_ticks <= pwdata[15:0];
                REG_ALARM_HOLD:  cfg_reg.alarm_hold_ticks  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SETTLE:      prdata = {16'd0, cfg_reg.settle_ticks};
            REG_BLINK_HALF:  prdata = {16'd0, cfg_reg.blink_half_ticks};
            REG_BLINK_COUNT: prdata = {28'd0, cfg_reg.blink_count};
            REG_ENTRY_DELAY: prdata = {16'd0, cfg_reg.entry_delay_ticks};
            REG_ALARM_HOLD:  prdata = {16'd0, cfg_reg.alarm_hold_ticks};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// File: src/iac_step.sv
// One-tick mode update of the alarm sequencer and lamp decode.
module iac_step
    import iac_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  cfg_t                  cfg,
    input  ctl_t                  ctl,
    input  logic [TIMER_BITS-1:0] tick,
    input  logic                  button_pressed,
    input  logic                  motion_seen,
    output ctl_t                  ctl_next,
    output logic [TIMER_BITS-1:0] tick_next,
    output res_t                  res
);

    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TICK_MAX = {TIMER_BITS{1'b1}};

    logic [TIMER_BITS-1:0] tick_inc;
    logic [15:0]           len;
    logic                  done;
    logic [3:0]            blinks_inc;
    logic                  notify;

    assign tick_inc   = (tick == TICK_MAX) ? tick : tick + 1'b1;
    assign blinks_inc = ctl.blinks_done + 4'd1;

    always_comb
    begin
        case (ctl.mode)
            MODE_ARMING:   len = cfg.blink_half_ticks;
            MODE_ENTRY:    len = cfg.entry_delay_ticks;
            MODE_SOUNDING: len = cfg.alarm_hold_ticks;
            default:       len = cfg.settle_ticks;
        endcase
    end

    assign done = (CW'(tick_inc) >= CW'(len)) || (tick_inc == TICK_MAX);

    // next state
    always_comb
    begin
        ctl_next  = ctl;
        tick_next = tick;
        notify    = 1'b0;
        case (ctl.mode)
            MODE_DISARMED:
            begin
                if (button_pressed)
                begin
                    ctl_next.blinks_done = 4'd0;
                    tick_next            = '0;
                    if (cfg.blink_count == 4'd0)
                    begin
                        ctl_next.blink_lit = 1'b0;
                        ctl_next.mode      = MODE_ARMED;
                    end
                    else
                    begin
                        ctl_next.blink_lit = 1'b1;
                        ctl_next.mode      = MODE_ARMING;
                    end
                end
            end
            MODE_ARMING:
            begin
                tick_next = tick_inc;
                if (done)
                begin
                    tick_next = '0;
                    if (ctl.blink_lit)
                    begin
                        ctl_next.blink_lit = 1'b0;
                    end
                    else
                    begin
                        ctl_next.blinks_done = blinks_inc;
                        if (blinks_inc >= cfg.blink_count || blinks_inc == 4'd0)
                            ctl_next.mode = MODE_ARMED;
                        else
                            ctl_next.blink_lit = 1'b1;
                    end
                end
            end
            MODE_ARMED:
            begin
                if (button_pressed)
                begin
                    ctl_next.mode = MODE_SETTLING;
                    tick_next     = '0;
                end
                else if (motion_seen)
                begin
                    ctl_next.mode = MODE_ENTRY;
                    tick_next     = '0;
                end
            end
            MODE_ENTRY:
            begin
                if (button_pressed)
                begin
                    ctl_next.mode = MODE_SETTLING;
                    tick_next     = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                    if (done)
                    begin
                        ctl_next.mode = MODE_SOUNDING;
                        tick_next     = '0;
                    end
                end
            end
            MODE_SOUNDING:
            begin
                tick_next = tick_inc;
                if (done)
                begin
                    ctl_next.mode = MODE_LATCHED;
                    tick_next     = '0;
                    notify        = 1'b1;
                end
            end
            MODE_LATCHED:
            begin
                if (button_pressed)
                begin
                    ctl_next.mode = MODE_SETTLING;
                    tick_next     = '0;
                end
            end
            default:
            begin
                ctl_next.mode = MODE_SETTLING;
                tick_next     = tick_inc;
                if (done)
                begin
                    ctl_next.mode = MODE_DISARMED;
                    tick_next     = '0;
                end
            end
        endcase
    end

    // outputs, from the updated state
    always_comb
    begin
        res.status_lamp  = 1'b0;
        res.armed_lamp   = 1'b0;
        res.siren_lamp   = 1'b0;
        res.notify_pulse = notify;
        res.mode_code    = ctl_next.mode;
        case (ctl_next.mode)
            MODE_SETTLING, MODE_DISARMED: res.status_lamp = 1'b1;
            MODE_ARMING:                  res.status_lamp = ctl_next.blink_lit;
            MODE_ARMED, MODE_ENTRY:       res.armed_lamp  = 1'b1;
            MODE_SOUNDING:
            begin
                res.status_lamp = 1'b1;
                res.armed_lamp  = 1'b1;
                res.siren_lamp  = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// File: src/intruder_alarm_controller.sv
// Intruder alarm controller top level: tick stream in, lamp/mode stream out.
// A result is registered and appears on m_axis in the cycle after its tick item is accepted.
// Throughput: one item per cycle while m_axis is not stalled; the mode update and timer
// compare sit between the state registers and the output register.
// Reset: asynchronous, active low; mode settling, timer and blink state zero,
// config registers at their default values, output register empty.
module intruder_alarm_controller
    import iac_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,  // button_pressed, motion_seen
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // status_lamp, armed_lamp, siren_lamp, notify_pulse, mode_code[2:0]
    output logic [7:0]               m_axis_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    cfg_t                  cfg;
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [TIMER_BITS-1:0] tick_reg;
    logic [TIMER_BITS-1:0] tick_next;
    res_t                  res_next;
    res_t                  res_reg;
    logic                  out_valid_reg;
    logic                  in_fire;

    assign pready        = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    iac_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    iac_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cfg            (cfg),
        .ctl            (ctl_reg),
        .tick           (tick_reg),
        .button_pressed (s_axis_tdata[0]),
        .motion_seen    (s_axis_tdata[1]),
        .ctl_next       (ctl_next),
        .tick_next      (tick_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.mode        <= MODE_SETTLING;
            ctl_reg.blinks_done <= 4'd0;
            ctl_reg.blink_lit   <= 1'b0;
            tick_reg            <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                ctl_reg  <= ctl_next;
                tick_reg <= tick_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg.mode_code, res_reg.notify_pulse,
                            res_reg.siren_lamp, res_reg.armed_lamp, res_reg.status_lamp};

endmodule

// File: src/iac_checker.sv
// Port-level assertions for the intruder alarm controller, bound to the top level.
module iac_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    localparam logic [2:0] CODE_SOUNDING = 3'd5;
    localparam logic [2:0] CODE_LATCHED  = 3'd6;
    localparam logic [2:0] CODE_UNUSED   = 3'd7;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_no_code7: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[6:4] != CODE_UNUSED)
        else $error("unused mode code on output");

    a_sounding_lamps: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[6:4] == CODE_SOUNDING |-> m_axis_tdata[2:0] == 3'b111)
        else $error("sounding without all lamps lit");

    a_notify_latched: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3] |->
            m_axis_tdata[6:4] == CODE_LATCHED && m_axis_tdata[2:0] == 3'b000)
        else $error("notify outside latched entry");

endmodule

bind intruder_alarm_controller iac_checker u_iac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/intruder_alarm_controller_tb.sv
// Testbench for the intruder alarm controller: directed and random tick streams.
module intruder_alarm_controller_tb;
    import iac_pkg::*;

    localparam int TICK_MAX = 65535;
    localparam int REG_UNUSED = 5;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic  status;
        logic  armed;
        logic  siren;
        logic  notify;
        mode_t mode;
    } lamps_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata;  // button_pressed, motion_seen
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    // status_lamp, armed_lamp, siren_lamp, notify_pulse, mode_code[2:0]
    logic [7:0]               m_axis_tdata;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    // alarm state tracked by the testbench
    logic [15:0] cfg_settle;
    logic [15:0] cfg_blink_half;
    logic [3:0]  cfg_blink_count;
    logic [15:0] cfg_entry_delay;
    logic [15:0] cfg_alarm_hold;
    mode_t       sim_mode;
    int          sim_ticks;
    logic [3:0]  sim_blinks;
    logic        sim_lit;

    lamps_t expected_lamps[$];
    int     mismatches;
    int     cycles;
    int     src_idle_pct;
    int     snk_idle_pct;
    int     hold_left;
    bit     stall_req;

    intruder_alarm_controller u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit timer_expired(int len);
        if (sim_ticks < TICK_MAX)
            sim_ticks++;
        return (sim_ticks >= len) || (sim_ticks >= TICK_MAX);
    endfunction

    function automatic void enter_mode(mode_t m);
        sim_mode = m;
        sim_ticks = 0;
    endfunction

    function automatic lamps_t alarm_step(logic btn, logic mot);
        lamps_t r;
        r = '0;
        r.notify = 1'b0;
        case (sim_mode)
            MODE_DISARMED:
            begin
                if (btn)
                begin
                    sim_blinks = '0;
                    if (cfg_blink_count == 0)
                    begin
                        sim_lit = 1'b0;
                        enter_mode(MODE_ARMED);
                    end
                    else
                    begin
                        sim_lit = 1'b1;
                        enter_mode(MODE_ARMING);
                    end
                end
            end
            MODE_ARMING:
            begin
                if (timer_expired(cfg_blink_half))
                begin
                    sim_ticks = 0;
                    if (sim_lit)
                        sim_lit = 1'b0;
                    else
                    begin
                        sim_blinks = sim_blinks + 4'd1;
                        if (sim_blinks >= cfg_blink_count || sim_blinks == 0)
                            enter_mode(MODE_ARMED);
                        else
                            sim_lit = 1'b1;
                    end
                end
            end
            MODE_ARMED:
            begin
                if (btn)
                    enter_mode(MODE_SETTLING);
                else if (mot)
                    enter_mode(MODE_ENTRY);
            end
            MODE_ENTRY:
            begin
                if (btn)
                    enter_mode(MODE_SETTLING);
                else if (timer_expired(cfg_entry_delay))
                    enter_mode(MODE_SOUNDING);
            end
            MODE_SOUNDING:
            begin
                if (timer_expired(cfg_alarm_hold))
                begin
                    enter_mode(MODE_LATCHED);
                    r.notify = 1'b1;
                end
            end
            MODE_LATCHED:
            begin
                if (btn)
                    enter_mode(MODE_SETTLING);
            end
            default:
            begin
                sim_mode = MODE_SETTLING;
                if (timer_expired(cfg_settle))
                    enter_mode(MODE_DISARMED);
            end
        endcase
        case (sim_mode)
            MODE_SETTLING, MODE_DISARMED: r.status = 1'b1;
            MODE_ARMING: r.status = sim_lit;
            MODE_ARMED, MODE_ENTRY: r.armed = 1'b1;
            MODE_SOUNDING:
            begin
                r.status = 1'b1;
                r.armed = 1'b1;
                r.siren = 1'b1;
            end
            default: ;
        endcase
        r.mode = sim_mode;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result checking and prediction, both on the pre-edge values
    always @(posedge clk)
    begin : monitor
        lamps_t got;
        lamps_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tdata[0];
                got.armed = m_axis_tdata[1];
                got.siren = m_axis_tdata[2];
                got.notify = m_axis_tdata[3];
                got.mode = mode_t'(m_axis_tdata[6:4]);
                if (expected_lamps.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_lamps.pop_front();
                    check_field("status_lamp", want.status, got.status);
                    check_field("armed_lamp", want.armed, got.armed);
                    check_field("siren_lamp", want.siren, got.siren);
                    check_field("notify_pulse", want.notify, got.notify);
                    check_field("mode_code", want.mode, got.mode);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_lamps.push_back(alarm_step(s_axis_tdata[0], s_axis_tdata[1]));
        end
    end

    // receiver side, with an optional long hold-off
    always @(posedge clk)
    begin
        if (stall_req)
        begin
            hold_left = LONG_HOLD;
            stall_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_lamps.size());
            $display("intruder_alarm_controller_tb: FAIL");
            $finish;
        end
    end

    task automatic send_tick(logic btn, logic mot);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, mot, btn};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_run(int n, logic btn, logic mot);
        repeat (n)
            send_tick(btn, mot);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_lamps.size() != 0);
        repeat (3)
            @(posedge clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] data);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_BITS'(idx * 4);
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SETTLE:      cfg_settle = data[15:0];
            REG_BLINK_HALF:  cfg_blink_half = data[15:0];
            REG_BLINK_COUNT: cfg_blink_count = data[3:0];
            REG_ENTRY_DELAY: cfg_entry_delay = data[15:0];
            REG_ALARM_HOLD:  cfg_alarm_hold = data[15:0];
            default: ;
        endcase
    endtask

    task automatic pick_timings;
        write_reg(REG_SETTLE, $urandom_range(0, 6));
        write_reg(REG_BLINK_HALF, $urandom_range(0, 3));
        write_reg(REG_BLINK_COUNT, ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 4));
        write_reg(REG_ENTRY_DELAY, $urandom_range(0, 8));
        write_reg(REG_ALARM_HOLD, $urandom_range(0, 6));
    endtask

    // reset timings: button and motion ignored while settling
    task automatic test_reset_timings;
        send_run(10, 1'b1, 1'b0);
        send_run(5, 1'b0, 1'b1);
        send_run(5, 1'b1, 1'b1);
    endtask

    // zero lengths, disarm from entry delay, ignored button and motion
    task automatic test_zero_lengths;
        write_reg(REG_SETTLE, 0);
        write_reg(REG_BLINK_HALF, 0);
        write_reg(REG_BLINK_COUNT, 0);
        write_reg(REG_ENTRY_DELAY, 0);
        write_reg(REG_ALARM_HOLD, 0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        write_reg(REG_BLINK_COUNT, 1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
    endtask

    // longest lengths, fifteen blinks, masked and unused writes
    task automatic test_extremes;
        write_reg(REG_SETTLE, 32'hFFFF);
        write_reg(REG_BLINK_HALF, 32'hFFFF);
        write_reg(REG_BLINK_COUNT, 1);
        write_reg(REG_ENTRY_DELAY, 32'hFFFF);
        write_reg(REG_ALARM_HOLD, 32'hFFFF);
        send_run(6, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_run(4, 1'b0, 1'b1);
        write_reg(REG_SETTLE, 0);
        write_reg(REG_BLINK_HALF, 32'hABCD_0001);
        write_reg(REG_BLINK_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, $urandom);
        send_run(2, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_run(40, 1'b0, 1'b1);
        write_reg(REG_ENTRY_DELAY, 1);
        write_reg(REG_ALARM_HOLD, 1);
        send_run(6, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
    endtask

    task automatic test_random(int n, int src_pct, int snk_pct);
        logic btn;
        logic mot;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int i = 0; i < n; i++)
        begin
            if (i % (n / 2) == 0)
                pick_timings();
            mot = $urandom_range(0, 1);
            case (sim_mode)
                MODE_DISARMED: btn = ($urandom_range(0, 99) < 35);
                MODE_ARMED:
                begin
                    btn = ($urandom_range(0, 99) < 8);
                    mot = ($urandom_range(0, 99) < 40);
                end
                MODE_ENTRY: btn = ($urandom_range(0, 99) < 10);
                MODE_LATCHED: btn = ($urandom_range(0, 99) < 30);
                default: btn = ($urandom_range(0, 99) < 15);
            endcase
            send_tick(btn, mot);
        end
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_backpressure;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_tick($urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        cycles = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_left = 0;
        stall_req = 1'b0;
        cfg_settle = SETTLE_RESET;
        cfg_blink_half = BLINK_HALF_RESET;
        cfg_blink_count = BLINK_COUNT_RESET;
        cfg_entry_delay = ENTRY_DELAY_RESET;
        cfg_alarm_hold = ALARM_HOLD_RESET;
        sim_mode = MODE_SETTLING;
        sim_ticks = 0;
        sim_blinks = '0;
        sim_lit = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_timings();
        test_zero_lengths();
        test_extremes();
        test_random(65, 0, 0);
        test_random(65, 45, 0);
        test_random(65, 0, 45);
        test_random(65, 31, 31);
        test_backpressure();

        drain();
        repeat (5)
            @(posedge clk);
        if (mismatches == 0)
            $display("intruder_alarm_controller_tb: PASS");
        else
            $display("intruder_alarm_controller_tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
src/iac_pkg.sv
src/iac_cfg_regs.sv
src/iac_step.sv
src/intruder_alarm_controller.sv
src/iac_checker.sv
sim/intruder_alarm_controller_tb.sv
